/* hdl/lpfc_pkg.sv */
`timescale 1ns / 1ps

package lpfc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 16;

    localparam int DIV_W = 32 + FRAC_BITS;
    localparam int WGT_W = FRAC_BITS + 1;
    localparam int TOT_W = 49;
    localparam int CFG_W = 33;
    localparam int IDX_W = 3;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOT_W-1:0] FOREVER_TIME = TOT_W'(64'd1000000 << FRAC_BITS);
    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

    localparam logic [IDX_W-1:0] REG_CLIP_LENGTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOOP_BEGIN      = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOOP_FINISH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_REPEAT_LIMIT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEED_FACTOR    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FADE_IN_LENGTH  = 3'd5;
    localparam logic [IDX_W-1:0] REG_FADE_OUT_LENGTH = 3'd6;
    localparam logic [IDX_W-1:0] REG_FADE_MODES      = 3'd7;

    localparam logic [1:0] FIN_AFTER   = 2'd0;
    localparam logic [1:0] FIN_BEFORE  = 2'd1;
    localparam logic [1:0] FOUT_AFTER  = 2'd0;
    localparam logic [1:0] FOUT_REPEAT = 2'd1;
    localparam logic [1:0] FOUT_BEFORE = 2'd2;

    typedef struct packed {
        logic [23:0] elapsed;
        logic        fade_out_request;
    } in_item_t;

    typedef struct packed {
        logic        active;
        logic [16:0] fade_weight;
        logic [39:0] played_time;
    } out_item_t;

endpackage

/* hdl/loop_playback_fade_controller.sv */
`timescale 1ns / 1ps
// loop playback and fade controller
// input channel (in_valid/in_ready/in_data): one beat per tick, carrying the
// elapsed time and a fade-out request. output channel (out_valid/out_ready/
// out_data): one beat per tick with the active flag, fade weight and played time.
// configuration: cfg_we/cfg_index/cfg_data, one register per cycle, no wait.
// an accepted tick runs through a small sequencer around one shared restoring
// divider and a few small multipliers; a loop wrap and each weight division
// (fade-in, fade-out) add a pass through the divider. the sequencer returns
// to idle in the same cycle as the result is registered, so the next tick
// can be accepted while the result is presented.
// in_ready is high only while the sequencer is idle.
// the result sits in an output register; the next tick is accepted while it
// waits, but that tick cannot finish until the receiver takes the previous beat.
// reset returns the registers to their defaults, position and pass count to
// zero, fade-in pending, no fade-out, and empties the output register.
module loop_playback_fade_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  lpfc_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lpfc_pkg::out_item_t        out_data,
    input  logic                       cfg_we,
    input  logic [lpfc_pkg::IDX_W-1:0] cfg_index,
    input  logic [lpfc_pkg::CFG_W-1:0] cfg_data
);
    import lpfc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIN      = 4'd1;
    localparam logic [3:0] S_ADV      = 4'd2;
    localparam logic [3:0] S_WRAP_MUL = 4'd3;
    localparam logic [3:0] S_WRAP_UPD = 4'd4;
    localparam logic [3:0] S_EXTRA    = 4'd5;
    localparam logic [3:0] S_PLAY     = 4'd6;
    localparam logic [3:0] S_TOTMUL   = 4'd7;
    localparam logic [3:0] S_TOTAL    = 4'd8;
    localparam logic [3:0] S_ACT      = 4'd9;
    localparam logic [3:0] S_W1       = 4'd10;
    localparam logic [3:0] S_W1_DONE  = 4'd11;
    localparam logic [3:0] S_W2       = 4'd12;
    localparam logic [3:0] S_W2_DONE  = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;
    localparam logic [3:0] S_DIV      = 4'd15;

    logic [31:0] clip_len_reg, loop_begin_reg, fil_reg, fol_reg;
    logic [32:0] loop_finish_reg;
    logic [16:0] repeat_limit_reg;
    logic [15:0] speed_reg;
    logic [3:0]  modes_reg;

    logic [31:0] pos_reg, pos_next, fclk_reg, fclk_next;
    logic [COUNT_BITS-1:0] pass_reg, pass_next;
    logic fin_reg, fin_next, fout_reg, fout_next;

    logic [3:0] state_reg, state_next, ret_reg, ret_next;
    logic [31:0] scaled_reg, scaled_next;
    logic skip_reg, skip_next, act_reg, act_next, reached_reg, reached_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] k_reg, k_next;
    logic [41:0] extra_reg, extra_next;
    logic [39:0] t_reg, t_next;
    logic [47:0] tmul_reg, tmul_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic [WGT_W-1:0] w1_reg, w1_next, w2_reg, w2_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [31:0] rem_reg, rem_next, dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic [1:0]  im, om;
    logic        forever_rep;
    logic [31:0] e_a, s_a, e_r, s_r, w_r;
    logic [39:0] mul_in;
    logic [32:0] sum33, pass_sum;
    logic [31:0] sum32;
    logic [32:0] rs;
    logic        qbit;
    logic signed [44:0] tsum;
    logic [TOT_W-1:0] tot_c;
    logic signed [51:0] dval;
    logic [WGT_W-1:0] qw;

    assign im = modes_reg[3:2];
    assign om = modes_reg[1:0];
    assign forever_rep = repeat_limit_reg[16];

    always_comb
    begin
        e_a = clip_len_reg;
        if (!loop_finish_reg[32] && loop_finish_reg[31:0] < e_a)
        begin
            e_a = loop_finish_reg[31:0];
        end
        s_a = (loop_begin_reg < e_a) ? loop_begin_reg : e_a;
        s_r = (loop_begin_reg < clip_len_reg) ? loop_begin_reg : clip_len_reg;
        e_r = clip_len_reg;
        if (!loop_finish_reg[32])
        begin
            e_r = loop_finish_reg[31:0];
            if (e_r < s_r)
            begin
                e_r = s_r;
            end
            if (e_r > clip_len_reg)
            begin
                e_r = clip_len_reg;
            end
        end
        w_r = e_r - s_r;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign qw = dq_reg[WGT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        pos_next = pos_reg;
        pass_next = pass_reg;
        fclk_next = fclk_reg;
        fin_next = fin_reg;
        fout_next = fout_reg;
        scaled_next = scaled_reg;
        skip_next = skip_reg;
        act_next = act_reg;
        reached_next = reached_reg;
        prod_next = prod_reg;
        k_next = k_reg;
        extra_next = extra_reg;
        t_next = t_reg;
        tmul_next = tmul_reg;
        tot_next = tot_reg;
        w1_next = w1_reg;
        w2_next = w2_reg;
        dq_next = dq_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;
        mul_in = 40'(in_data.elapsed) * 40'(speed_reg);
        sum33 = 33'd0;
        sum32 = 32'd0;
        pass_sum = 33'd0;
        rs = 33'd0;
        qbit = 1'b0;
        tsum = 45'sd0;
        tot_c = 49'd0;
        dval = 52'sd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    scaled_next = mul_in[39:8];
                    skip_next = 1'b0;
                    act_next = 1'b1;
                    if (in_data.fade_out_request && !fout_reg)
                    begin
                        fout_next = 1'b1;
                        fclk_next = 32'd0;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (im == FIN_BEFORE)
                begin
                    if (fin_reg)
                    begin
                        sum33 = {1'b0, fclk_reg} + {1'b0, scaled_reg};
                        sum32 = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                        fclk_next = sum32;
                        if (sum32 >= fil_reg)
                        begin
                            fin_next = 1'b0;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    fin_next = 1'b0;
                end
                state_next = S_ADV;
            end
            S_ADV:
            begin
                state_next = S_EXTRA;
                if (!skip_reg && (!fout_reg || om == FOUT_REPEAT))
                begin
                    sum33 = {1'b0, pos_reg} + {1'b0, scaled_reg};
                    sum32 = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                    pos_next = sum32;
                    if (sum32 > e_a)
                    begin
                        if (e_a == s_a)
                        begin
                            pos_next = s_a;
                            if (!forever_rep)
                            begin
                                pass_next = (33'(repeat_limit_reg) > 33'(COUNT_MAX))
                                            ? COUNT_MAX
                                            : COUNT_BITS'(repeat_limit_reg);
                            end
                        end
                        else
                        begin
                            dq_next = DIV_W'(sum32 - s_a - 32'd1);
                            dsr_next = e_a - s_a;
                            rem_next = 32'd0;
                            cnt_next = '0;
                            ret_next = S_WRAP_MUL;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_WRAP_MUL:
            begin
                k_next = dq_reg[31:0];
                prod_next = 64'(dq_reg[31:0]) * 64'(dsr_reg);
                state_next = S_WRAP_UPD;
            end
            S_WRAP_UPD:
            begin
                pos_next = pos_reg - prod_reg[31:0];
                pass_sum = {1'b0, k_reg} + 33'(pass_reg);
                pass_next = (pass_sum > 33'(COUNT_MAX)) ? COUNT_MAX
                            : COUNT_BITS'(pass_sum);
                state_next = S_EXTRA;
            end
            S_EXTRA:
            begin
                prod_next = 64'(pass_reg - COUNT_BITS'(1)) * 64'(w_r);
                state_next = S_PLAY;
            end
            S_PLAY:
            begin
                extra_next = (prod_reg > 64'(42'h200_0000_0000)) ? 42'h200_0000_0000
                             : prod_reg[41:0];
                state_next = S_TOTMUL;
            end
            S_TOTMUL:
            begin
                if (pass_reg == '0)
                begin
                    t_next = 40'(pos_reg);
                end
                else
                begin
                    tsum = $signed(45'(pos_reg)) + $signed(45'(e_r))
                           - $signed(45'(s_r)) + $signed(45'(extra_reg));
                    if (tsum < 0)
                    begin
                        t_next = 40'd0;
                    end
                    else if (tsum > $signed(45'(MAX40)))
                    begin
                        t_next = MAX40;
                    end
                    else
                    begin
                        t_next = tsum[39:0];
                    end
                end
                tmul_next = 48'(repeat_limit_reg[15:0]) * 48'(w_r);
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                tot_c = forever_rep ? FOREVER_TIME : (TOT_W'(e_r) + TOT_W'(tmul_reg));
                tot_next = tot_c;
                reached_next = !forever_rep && (TOT_W'(t_reg) >= tot_c);
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (!skip_reg)
                begin
                    sum33 = {1'b0, fclk_reg} + {1'b0, scaled_reg};
                    sum32 = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                    if (om == FOUT_AFTER || om == FOUT_REPEAT)
                    begin
                        if (fout_reg || reached_reg)
                        begin
                            fout_next = 1'b1;
                            if (!fout_reg)
                            begin
                                sum32 = scaled_reg;
                            end
                            fclk_next = sum32;
                            if (sum32 >= fol_reg)
                            begin
                                act_next = 1'b0;
                            end
                        end
                    end
                    else if (om == FOUT_BEFORE)
                    begin
                        if (reached_reg)
                        begin
                            act_next = 1'b0;
                        end
                        else if (fout_reg)
                        begin
                            fclk_next = sum32;
                            if (sum32 >= fol_reg)
                            begin
                                act_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        if (reached_reg || fout_reg)
                        begin
                            act_next = 1'b0;
                        end
                    end
                end
                state_next = S_W1;
            end
            S_W1:
            begin
                w1_next = WGT_ONE;
                state_next = S_W2;
                rem_next = 32'd0;
                cnt_next = '0;
                ret_next = S_W1_DONE;
                dsr_next = fil_reg;
                if (im == FIN_AFTER)
                begin
                    if (t_reg < 40'(fil_reg))
                    begin
                        dq_next = DIV_W'(t_reg[31:0]) << FRAC_BITS;
                        state_next = S_DIV;
                    end
                end
                else if (im == FIN_BEFORE)
                begin
                    if (fin_reg && fil_reg != 32'd0 && fclk_reg < fil_reg)
                    begin
                        dq_next = DIV_W'(fclk_reg) << FRAC_BITS;
                        state_next = S_DIV;
                    end
                end
            end
            S_W1_DONE:
            begin
                w1_next = qw;
                state_next = S_W2;
            end
            S_W2:
            begin
                w2_next = WGT_ONE;
                state_next = S_EMIT;
                rem_next = 32'd0;
                cnt_next = '0;
                ret_next = S_W2_DONE;
                dsr_next = fol_reg;
                dval = $signed(52'(t_reg)) - $signed(52'(tot_reg)) + $signed(52'(fol_reg));
                if (om == FOUT_AFTER || om == FOUT_REPEAT)
                begin
                    if (fout_reg)
                    begin
                        if (fclk_reg >= fol_reg)
                        begin
                            w2_next = '0;
                        end
                        else
                        begin
                            dq_next = DIV_W'(fclk_reg) << FRAC_BITS;
                            state_next = S_DIV;
                        end
                    end
                end
                else if (om == FOUT_BEFORE)
                begin
                    if (dval > 0 && fol_reg != 32'd0 && dval < $signed(52'(fol_reg)))
                    begin
                        dq_next = DIV_W'(dval[31:0]) << FRAC_BITS;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    if (fout_reg)
                    begin
                        w2_next = '0;
                    end
                end
            end
            S_W2_DONE:
            begin
                w2_next = (om == FOUT_BEFORE) ? qw : (WGT_ONE - qw);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.active = act_reg;
                    out_data_next.fade_weight = 17'((w1_reg < w2_reg) ? w1_reg : w2_reg);
                    out_data_next.played_time = t_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                rs = {rem_reg, dq_reg[DIV_W-1]};
                qbit = (rs >= {1'b0, dsr_reg});
                rem_next = qbit ? 32'(rs - {1'b0, dsr_reg}) : rs[31:0];
                dq_next = {dq_reg[DIV_W-2:0], qbit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_len_reg <= 32'd0;
            loop_begin_reg <= 32'd0;
            loop_finish_reg <= {CFG_W{1'b1}};
            repeat_limit_reg <= 17'd0;
            speed_reg <= 16'd256;
            fil_reg <= 32'd0;
            fol_reg <= 32'd0;
            modes_reg <= 4'd0;
            pos_reg <= 32'd0;
            pass_reg <= '0;
            fclk_reg <= 32'd0;
            fin_reg <= 1'b1;
            fout_reg <= 1'b0;
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CLIP_LENGTH:     clip_len_reg <= cfg_data[31:0];
                    REG_LOOP_BEGIN:      loop_begin_reg <= cfg_data[31:0];
                    REG_LOOP_FINISH:     loop_finish_reg <= cfg_data;
                    REG_REPEAT_LIMIT:    repeat_limit_reg <= cfg_data[16:0];
                    REG_SPEED_FACTOR:    speed_reg <= cfg_data[15:0];
                    REG_FADE_IN_LENGTH:  fil_reg <= cfg_data[31:0];
                    REG_FADE_OUT_LENGTH: fol_reg <= cfg_data[31:0];
                    REG_FADE_MODES:      modes_reg <= cfg_data[3:0];
                    default:             modes_reg <= modes_reg;
                endcase
            end
            pos_reg <= pos_next;
            pass_reg <= pass_next;
            fclk_reg <= fclk_next;
            fin_reg <= fin_next;
            fout_reg <= fout_next;
            state_reg <= state_next;
            ret_reg <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
        skip_reg <= skip_next;
        act_reg <= act_next;
        reached_reg <= reached_next;
        prod_reg <= prod_next;
        k_reg <= k_next;
        extra_reg <= extra_next;
        t_reg <= t_next;
        tmul_reg <= tmul_next;
        tot_reg <= tot_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        dq_reg <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* hdl/lpfc_checker.sv */
`timescale 1ns / 1ps

module lpfc_props (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input lpfc_pkg::out_item_t out_data
);
    import lpfc_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled output beat changed");

    // weight never above one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.fade_weight <= 17'd65536))
        else $error("fade weight above one");

    // one tick at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while busy");

    // a tick keeps the block busy past its fade-in step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 !in_ready)
        else $error("tick finished too early");

endmodule

bind loop_playback_fade_controller lpfc_props u_lpfc_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
